/* src/vars_pkg.sv */
// types and constants shared by the aiming sequencer and its channel interfaces
package vars_pkg;

    // field widths
    localparam int OFFSET_W  = 14;
    localparam int ROT_W     = 17;
    localparam int GAIN_W    = 16;
    localparam int TIMEOUT_W = 10;
    localparam int WAIT_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // request opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // drive command codes
    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_TURN = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ROT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd3;

    // configuration reset values
    localparam logic [GAIN_W-1:0]    GAIN_RST    = 16'd1114;
    localparam logic [GAIN_W-1:0]    MIN_ROT_RST = 16'd10813;
    localparam logic [GAIN_W-1:0]    MAX_ROT_RST = 16'd22938;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd250;

    // Q15 full scale and the 0.5 degree deadband in Q8
    localparam logic [ROT_W-1:0]           FULL_Q15    = 17'd32768;
    localparam logic signed [OFFSET_W-1:0] DEADBAND_Q8 = 14'sd128;

    // tick counts for the wait mode
    localparam logic [WAIT_W-1:0] TURN_WAIT = 3'd2;
    localparam logic [WAIT_W-1:0] LOOK_WAIT = 3'd4;

    // reported mode codes
    localparam logic [2:0] PHASE_AIM     = 3'd0;
    localparam logic [2:0] PHASE_WAIT    = 3'd1;
    localparam logic [2:0] PHASE_RECHECK = 3'd2;
    localparam logic [2:0] PHASE_READY   = 3'd3;
    localparam logic [2:0] PHASE_DONE    = 3'd4;

    // sequencer modes, one-hot
    typedef enum logic [4:0] {
        PH_AIM     = 5'b00001,
        PH_WAIT    = 5'b00010,
        PH_RECHECK = 5'b00100,
        PH_READY   = 5'b01000,
        PH_DONE    = 5'b10000
    } phase_t;

    // one-hot mode to reported code
    function automatic logic [2:0] phase_code(input phase_t p);
        logic [2:0] code;
        case (p)
            PH_AIM:     code = PHASE_AIM;
            PH_WAIT:    code = PHASE_WAIT;
            PH_RECHECK: code = PHASE_RECHECK;
            PH_READY:   code = PHASE_READY;
            default:    code = PHASE_DONE;
        endcase
        return code;
    endfunction

endpackage

/* src/vars_if.sv */
// valid/ready channel interfaces for requests, results and register writes

interface vars_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    op;
    logic signed [vars_pkg::OFFSET_W-1:0]    offset;
    logic                                    found;

    modport source (output valid, op, offset, found, input ready);
    modport sink   (input valid, op, offset, found, output ready);
endinterface

interface vars_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              drive_cmd;
    logic signed [vars_pkg::ROT_W-1:0]       rotation;
    logic                                    ready_res;
    logic                                    finished;
    logic [2:0]                              phase;

    modport source (output valid, drive_cmd, rotation, ready_res, finished, phase,
                    input ready);
    modport sink   (input valid, drive_cmd, rotation, ready_res, finished, phase,
                    output ready);
endinterface

interface vars_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic [vars_pkg::CFG_IDX_W-1:0]          index;
    logic [vars_pkg::CFG_DAT_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/vision_aim_rotation_sequencer_top.sv */
// vision aiming sequencer: mode sequencing and proportional turn command
//
// in_ch carries one request per item: a start (op = 1) or a loop tick with
// the target offset (Q8 degrees) and the found flag. out_ch returns exactly
// one result per request: drive command, Q15 rotation, ready pulse, finished
// flag and the mode after the step. cfg writes gain, min_rotation,
// max_rotation and timeout_ticks by index 0..3 and is always ready; it must be
// written only while no request is in flight, which the block does not enforce.
// A request is captured in an input register when accepted. Once the result
// register is empty or being taken, the request is evaluated against the
// sequencer state, that state is updated and the result register is loaded.
// Throughput is one request per cycle while the receiver takes every result:
// the single 17x14 multiply and the clip compares sit between the input
// register and the result register.
// When the receiver stalls, the result holds and the input register still
// takes one more request; in_ch.ready drops only when both are full.
// Reset clears both stages, loads the register defaults and leaves the
// sequencer in the done mode and not running.
module vision_aim_rotation_sequencer_top (
    input  logic              clk,
    input  logic              rst_n,
    vars_in_if.sink           in_ch,
    vars_out_if.source        out_ch,
    vars_cfg_if.sink          cfg
);

    localparam logic [vars_pkg::TIMEOUT_W-1:0] ELAPSED_MAX = '1;

    // configuration registers
    logic [vars_pkg::GAIN_W-1:0]    gain_reg;
    logic [vars_pkg::GAIN_W-1:0]    min_rot_reg;
    logic [vars_pkg::GAIN_W-1:0]    max_rot_reg;
    logic [vars_pkg::TIMEOUT_W-1:0] timeout_reg;

    // input stage
    logic                                   s1_valid_reg;
    logic                                   s1_op_reg;
    logic signed [vars_pkg::OFFSET_W-1:0]   s1_offset_reg;
    logic                                   s1_found_reg;

    // sequencer state
    vars_pkg::phase_t                  phase_reg, phase_next;
    vars_pkg::phase_t                  after_wait_reg, after_wait_next;
    logic [vars_pkg::WAIT_W-1:0]       wait_left_reg, wait_left_next, wait_dec;
    logic [vars_pkg::TIMEOUT_W-1:0]    elapsed_reg, elapsed_next;
    logic                              running_reg, running_next;

    // result register
    logic                                out_valid_reg;
    logic [1:0]                          cmd_reg, cmd_next;
    logic signed [vars_pkg::ROT_W-1:0]   rot_reg, rot_next;
    logic                                rdy_reg, rdy_next;
    logic                                fin_reg, fin_next;
    logic [2:0]                          code_reg;

    // turn arithmetic
    logic signed [30:0]                  product;
    logic signed [23:0]                  scaled;
    logic signed [23:0]                  min_ext;
    logic signed [23:0]                  turn_sum;
    logic [vars_pkg::ROT_W-1:0]          lim;
    logic signed [23:0]                  lim_ext;
    logic signed [vars_pkg::ROT_W-1:0]   turn_val;
    logic                                off_target;

    logic advance;

    // handshakes
    assign advance      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= vars_pkg::GAIN_RST;
            min_rot_reg <= vars_pkg::MIN_ROT_RST;
            max_rot_reg <= vars_pkg::MAX_ROT_RST;
            timeout_reg <= vars_pkg::TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                vars_pkg::REG_GAIN:    gain_reg    <= cfg.data;
                vars_pkg::REG_MIN_ROT: min_rot_reg <= cfg.data;
                vars_pkg::REG_MAX_ROT: max_rot_reg <= cfg.data;
                vars_pkg::REG_TIMEOUT: timeout_reg <= cfg.data[vars_pkg::TIMEOUT_W-1:0];
                default:               gain_reg    <= gain_reg;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_op_reg     <= in_ch.op;
            s1_offset_reg <= in_ch.offset;
            s1_found_reg  <= in_ch.found;
        end
    end

    // deadband test
    assign off_target = s1_found_reg &&
                        (s1_offset_reg < -vars_pkg::DEADBAND_Q8 ||
                         s1_offset_reg > vars_pkg::DEADBAND_Q8);

    // gain times offset, floor shift by 9, then the minimum drive
    assign product  = $signed({1'b0, gain_reg}) * s1_offset_reg;
    assign scaled   = {{2{product[30]}}, product[30:9]};
    assign min_ext  = $signed({8'd0, min_rot_reg});
    assign turn_sum = (s1_offset_reg > 14'sd0) ? scaled + min_ext : scaled - min_ext;

    // clip to the rotation limit, itself capped at full scale
    assign lim     = ({1'b0, max_rot_reg} > vars_pkg::FULL_Q15) ? vars_pkg::FULL_Q15
                                                                 : {1'b0, max_rot_reg};
    assign lim_ext = $signed({7'd0, lim});

    always_comb
    begin
        if (turn_sum > lim_ext)
            turn_val = lim_ext[vars_pkg::ROT_W-1:0];
        else if (turn_sum < -lim_ext)
            turn_val = $signed(-lim_ext[vars_pkg::ROT_W-1:0]);
        else
            turn_val = turn_sum[vars_pkg::ROT_W-1:0];
    end

    // wait countdown
    assign wait_dec = (wait_left_reg != '0) ? wait_left_reg - 1'b1 : wait_left_reg;

    // sequencer step
    always_comb
    begin
        phase_next      = phase_reg;
        after_wait_next = after_wait_reg;
        wait_left_next  = wait_left_reg;
        elapsed_next    = elapsed_reg;
        running_next    = running_reg;
        cmd_next        = vars_pkg::CMD_NONE;
        rot_next        = '0;
        rdy_next        = 1'b0;
        fin_next        = 1'b0;
        if (s1_op_reg == vars_pkg::OP_START)
        begin
            phase_next      = vars_pkg::PH_AIM;
            after_wait_next = vars_pkg::PH_DONE;
            wait_left_next  = '0;
            elapsed_next    = '0;
            running_next    = 1'b1;
        end
        else if (running_reg)
        begin
            case (phase_reg)
                vars_pkg::PH_WAIT:
                begin
                    wait_left_next = wait_dec;
                    if (wait_dec == '0)
                        phase_next = after_wait_reg;
                end
                vars_pkg::PH_AIM:
                begin
                    if (off_target)
                    begin
                        rot_next        = turn_val;
                        cmd_next        = vars_pkg::CMD_TURN;
                        wait_left_next  = vars_pkg::TURN_WAIT;
                        after_wait_next = vars_pkg::PH_AIM;
                    end
                    else
                    begin
                        wait_left_next  = vars_pkg::LOOK_WAIT;
                        after_wait_next = vars_pkg::PH_RECHECK;
                    end
                    phase_next = vars_pkg::PH_WAIT;
                end
                vars_pkg::PH_RECHECK:
                    phase_next = off_target ? vars_pkg::PH_AIM : vars_pkg::PH_READY;
                vars_pkg::PH_READY:
                begin
                    rdy_next   = 1'b1;
                    phase_next = vars_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = vars_pkg::PH_DONE;
                    cmd_next   = vars_pkg::CMD_STOP;
                end
            endcase
            if (elapsed_reg != ELAPSED_MAX)
                elapsed_next = elapsed_reg + 1'b1;
            // finish on done or timeout, stop overrides a turn
            if (phase_next == vars_pkg::PH_DONE || elapsed_next >= timeout_reg)
            begin
                running_next = 1'b0;
                fin_next     = 1'b1;
                cmd_next     = vars_pkg::CMD_STOP;
                rot_next     = '0;
            end
        end
    end

    // sequencer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= vars_pkg::PH_DONE;
            after_wait_reg <= vars_pkg::PH_DONE;
            wait_left_reg  <= '0;
            elapsed_reg    <= '0;
            running_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            after_wait_reg <= after_wait_next;
            wait_left_reg  <= wait_left_next;
            elapsed_reg    <= elapsed_next;
            running_reg    <= running_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg  <= cmd_next;
            rot_reg  <= rot_next;
            rdy_reg  <= rdy_next;
            fin_reg  <= fin_next;
            code_reg <= vars_pkg::phase_code(phase_next);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.drive_cmd = cmd_reg;
    assign out_ch.rotation  = rot_reg;
    assign out_ch.ready_res = rdy_reg;
    assign out_ch.finished  = fin_reg;
    assign out_ch.phase     = code_reg;

`ifndef SYNTH
    // a finished result always commands a stop
    a_fin_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fin_reg |-> cmd_reg == vars_pkg::CMD_STOP)
        else $error("finished result without stop command");

    // rotation is only nonzero on a turn command
    a_rot_turn_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cmd_reg != vars_pkg::CMD_TURN |-> rot_reg == '0)
        else $error("rotation set without turn command");

    // the command ends only together with a finished result
    a_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(running_reg) |-> out_valid_reg && fin_reg)
        else $error("sequencer stopped without finished result");

    // a held request is never overwritten
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_op_reg)
                                     && $stable(s1_offset_reg))
        else $error("pending request lost");
`endif

endmodule
